// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the decoder RTL.
// Needs a clock and an active-low reset name at each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is low
`define PD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never hold outside reset
`define PD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `PD_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/pd_pkg.sv =====
// Shared types, constants and hex helpers for the percent decoder.
// No dependencies.
`default_nettype none

package pd_pkg;

  localparam logic [7:0] PCT_CHAR   = 8'h25;
  localparam int         FIFO_DEPTH = 4;
  localparam int         PTR_W      = $clog2(FIFO_DEPTH);
  localparam int         CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One command: up to three bytes to emit, last flag on the final one
  typedef struct packed {
    logic [1:0]       cnt;
    logic [7:0]       b2;
    logic [7:0]       b1;
    logic [7:0]       b0;
    logic             last;
  } pd_cmd_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } pd_fifo_stat_t;

  function automatic logic hex_ok(input logic [7:0] b);
    hex_ok = (b >= 8'h30 && b <= 8'h39) ||
             (b >= 8'h41 && b <= 8'h46) ||
             (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h41 + 8'd10;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h61 + 8'd10;
    end
    hex_val = v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pd_front.sv =====
// Front end: accepts input items, tracks a pending escape, builds commands.
// Depends on pd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,   // [7:0] in_byte
  input  wire logic           in_tlast,
  input  wire pd_pkg::pd_fifo_stat_t fifo_stat,
  output logic                push,
  output pd_pkg::pd_cmd_t     push_cmd
);
  import pd_pkg::*;

  typedef enum logic [1:0] {PEND_NONE, PEND_PCT, PEND_DIGIT} pend_t;

  pend_t      pend_r, pend_nxt;
  logic [7:0] held_r, held_nxt;
  logic       in_acc;
  logic       is_hex;
  logic       starts_pct;
  logic [7:0] dec_val;

  assign in_tready  = !fifo_stat.full;
  assign in_acc     = in_tvalid && in_tready;
  assign is_hex     = hex_ok(in_tdata);
  assign starts_pct = (in_tdata == PCT_CHAR) && !in_tlast;
  assign dec_val    = {hex_val(held_r), hex_val(in_tdata)};

  // Classify the byte against the held escape
  always_comb begin
    push_cmd      = '0;
    push_cmd.last = in_tlast;
    pend_nxt      = pend_r;
    held_nxt      = held_r;
    case (pend_r)
      PEND_PCT: begin
        if (is_hex) begin
          if (in_tlast) begin
            push_cmd.cnt = 2'd2;
            push_cmd.b0  = PCT_CHAR;
            push_cmd.b1  = in_tdata;
            pend_nxt     = PEND_NONE;
          end else begin
            held_nxt = in_tdata;
            pend_nxt = PEND_DIGIT;
          end
        end else if (starts_pct) begin
          push_cmd.cnt = 2'd1;
          push_cmd.b0  = PCT_CHAR;
          pend_nxt     = PEND_PCT;
        end else begin
          push_cmd.cnt = 2'd2;
          push_cmd.b0  = PCT_CHAR;
          push_cmd.b1  = in_tdata;
          pend_nxt     = PEND_NONE;
        end
      end
      PEND_DIGIT: begin
        if (is_hex) begin
          push_cmd.cnt = 2'd1;
          push_cmd.b0  = dec_val;
          pend_nxt     = PEND_NONE;
        end else if (starts_pct) begin
          push_cmd.cnt = 2'd2;
          push_cmd.b0  = PCT_CHAR;
          push_cmd.b1  = held_r;
          pend_nxt     = PEND_PCT;
        end else begin
          push_cmd.cnt = 2'd3;
          push_cmd.b0  = PCT_CHAR;
          push_cmd.b1  = held_r;
          push_cmd.b2  = in_tdata;
          pend_nxt     = PEND_NONE;
        end
      end
      default: begin
        if (starts_pct) begin
          pend_nxt = PEND_PCT;
        end else begin
          push_cmd.cnt = 2'd1;
          push_cmd.b0  = in_tdata;
          pend_nxt     = PEND_NONE;
        end
      end
    endcase
  end

  // Items that only absorb a byte queue nothing
  assign push = in_acc && (push_cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      held_r <= 8'h00;
    end else if (in_acc) begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

  `PD_ASSERT(a_last_clears, clk, rst_n, in_acc && in_tlast |=> pend_r == PEND_NONE,
             "string end left an escape pending")
  `PD_ASSERT_NEVER(a_push_full, clk, rst_n, push && fifo_stat.full,
                   "command pushed into a full queue")

endmodule

`default_nettype wire

// ===== rtl/pd_cmd_fifo.sv =====
// Small command queue between the front and back ends.
// Depends on pd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pd_cmd_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire pd_pkg::pd_cmd_t  push_cmd,
  input  wire logic             pop,
  output pd_pkg::pd_cmd_t       head_cmd,
  output pd_pkg::pd_fifo_stat_t stat
);
  import pd_pkg::*;

  pd_cmd_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `PD_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && stat.empty, "pop from an empty queue")
  `PD_ASSERT(a_ptr_track, clk, rst_n,
             CNT_W'(PTR_W'(wr_ptr_r - rd_ptr_r)) == (stat.full ? '0 : count_r),
             "queue pointers disagree with fill count")

endmodule

`default_nettype wire

// ===== rtl/pd_back.sv =====
// Back end: emits head command bytes, one item per cycle unless stalled.
// Depends on pd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pd_pkg::pd_cmd_t  head_cmd,
  input  wire pd_pkg::pd_fifo_stat_t fifo_stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_byte
  output logic                  out_tlast
);
  import pd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_acc;
  logic       at_end;

  assign out_tvalid = !fifo_stat.empty;
  assign out_acc    = out_tvalid && out_tready;
  assign at_end     = (idx_r == head_cmd.cnt - 2'd1);
  assign out_tlast  = head_cmd.last && at_end;
  assign pop        = out_acc && at_end;

  // Byte select within the command
  always_comb begin
    case (idx_r)
      2'd0:    out_tdata = head_cmd.b0;
      2'd1:    out_tdata = head_cmd.b1;
      2'd2:    out_tdata = head_cmd.b2;
      default: out_tdata = head_cmd.b0;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (out_acc) begin
      idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  `PD_ASSERT(a_idx_in_cmd, clk, rst_n,
             out_tvalid |-> (idx_r < head_cmd.cnt) && (head_cmd.cnt != 2'd0),
             "byte index beyond command length")

endmodule

`default_nettype wire

// ===== rtl/percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
// Depends on pd_pkg, pd_front, pd_cmd_fifo and pd_back.
//
// Usage:
//   Input channel in_*: one encoded byte per item on in_tdata, in_tlast on
//   the final byte of a string. Output channel out_*: one decoded byte per
//   item, out_tlast on the final decoded byte of the string.
//   An accepted byte is classified at once; the bytes it produces (zero to
//   three) sit in a four-entry command queue and, if the queue was empty,
//   appear on out_* in the next cycle.
//   The input takes one item per cycle while the queue has room. The output
//   gives one byte per cycle while out_tready is high, so an input that
//   yields three bytes holds the back end; the queue absorbs such bursts.
//   When the receiver stalls, the head byte holds and the input keeps
//   taking items until four commands are queued.
//   Reset (rst_n low, synchronous) empties the queue and drops any held
//   escape; no clearing pass is needed.
`default_nettype none

module percent_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast
);
  import pd_pkg::*;

  pd_fifo_stat_t fifo_stat;
  pd_cmd_t       push_cmd;
  pd_cmd_t       head_cmd;
  logic          push;
  logic          pop;

  pd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  pd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .fifo_stat  (fifo_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for percent_decoder: streams encoded strings, predicts the
// decoded bytes with its own escape tracker and checks every output item.
// Depends on pd_pkg (for the '%' code) and the percent_decoder RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [7:0] PCT       = pd_pkg::PCT_CHAR;
  localparam int         N_RANDOM  = 200;
  localparam int         MAX_CYCLE = 200000;

  typedef enum logic [1:0] {ESC_NONE, ESC_PCT, ESC_DIGIT} esc_t;

  // one byte of an encoded string plus its pacing
  typedef struct {
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } enc_item_t;

  // one decoded byte as it should leave the block
  typedef struct {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  enc_item_t  send_q[$];
  dec_byte_t  decoded_q[$];

  // escape tracker of the predictor
  esc_t       esc_st = ESC_NONE;
  logic [7:0] held_char = 8'h00;

  bit         in_taken = 1'b0;
  int         rx_wait = 0;
  bit         rx_calm = 1'b0;
  int         n_queued = 0;
  int         n_accepted = 0;
  int         n_checked = 0;
  int         n_strings = 0;
  int         n_escapes = 0;
  int         n_broken = 0;
  int         n_fail = 0;
  int         n_cycle = 0;

  percent_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic bit is_hex(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [3:0] nibble_of(logic [7:0] b);
    logic [7:0] v;
    if (b <= "9") v = b - "0";
    else if (b <= "F") v = b - "A" + 8'd10;
    else v = b - "a" + 8'd10;
    return v[3:0];
  endfunction

  function automatic void emit(logic [7:0] b, logic l);
    dec_byte_t d;
    d.data = b;
    d.last = l;
    decoded_q.push_back(d);
  endfunction

  // byte seen with nothing held: a '%' opens an escape unless the string ends
  function automatic void take_plain(logic [7:0] b, logic l);
    if (b == PCT && !l) begin
      esc_st = ESC_PCT;
    end else begin
      esc_st = ESC_NONE;
      emit(b, l);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic l);
    case (esc_st)
      ESC_PCT: begin
        if (is_hex(b) && l) begin
          // string ends after one digit: flush both literally
          emit(PCT, 1'b0);
          emit(b, 1'b1);
          esc_st = ESC_NONE;
          n_broken++;
        end else if (is_hex(b)) begin
          held_char = b;
          esc_st = ESC_DIGIT;
        end else begin
          emit(PCT, 1'b0);
          n_broken++;
          take_plain(b, l);
        end
      end
      ESC_DIGIT: begin
        if (is_hex(b)) begin
          emit({nibble_of(held_char), nibble_of(b)}, l);
          esc_st = ESC_NONE;
          n_escapes++;
        end else begin
          emit(PCT, 1'b0);
          emit(held_char, 1'b0);
          n_broken++;
          take_plain(b, l);
        end
      end
      default: begin
        take_plain(b, l);
      end
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------

  task automatic add_item(input logic [7:0] b, input logic l, input bit calm, input bit drain);
    enc_item_t it;
    it.data  = b;
    it.last  = l;
    it.gap   = calm ? 0 : $urandom_range(0, 7);
    it.drain = drain;
    send_q.push_back(it);
    n_queued++;
  endtask

  function automatic logic [7:0] rand_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 10) return "0" + v;
    return ($urandom_range(0, 1) ? "a" : "A") + v - 4'd10;
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] b;
    logic [7:0] edges[8] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};
    if ($urandom_range(0, 1)) return edges[$urandom_range(0, 7)];
    b = 8'($urandom_range(0, 255));
    while (is_hex(b)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // ---------------- driver ----------------

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (send_q.size() != 0 && send_q[0].gap != 0) begin
        send_q[0].gap = send_q[0].gap - 1;
        in_tvalid <= 1'b0;
      end else if (send_q.size() != 0 && !(send_q[0].drain && decoded_q.size() != 0)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= send_q[0].data;
        in_tlast  <= send_q[0].last;
        void'(send_q.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls; a calm stretch keeps ready high
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_wait != 0) begin
        out_tready <= 1'b0;
        rx_wait = rx_wait - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    dec_byte_t want;
    n_cycle++;
    if (n_cycle >= MAX_CYCLE) begin
      $display("timeout after %0d cycles", n_cycle);
      $display("status: fail");
      $finish;
    end else if (rst_n) begin
      // predict each accepted input item
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast);
        in_taken = 1'b1;
        n_accepted++;
        if (in_tlast) n_strings++;
      end
      // check each accepted output item against the oldest expected byte
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected output item: out_byte %0h out_last %0b", out_tdata, out_tlast);
          n_fail++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte mismatch: expected %0h, actual %0h", want.data, out_tdata);
            n_fail++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last mismatch: expected %0b, actual %0b", want.last, out_tlast);
            n_fail++;
          end
        end
        n_checked++;
        if (n_checked % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    logic [7:0] sbuf[$];
    int         n_tok;
    int         kind;
    int         n_dir;
    bit         calm;
    bit         drain;
    logic [7:0] tok_b;

    // directed: plain extremes, decoded escapes, broken and partial escapes
    add_item(8'h00, 1'b0, 1'b0, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0, 1'b0);
    // escape completed on the final byte
    add_item(PCT, 1'b0, 1'b0, 1'b0);
    add_item("4", 1'b0, 1'b0, 1'b0);
    add_item("1", 1'b1, 1'b0, 1'b0);
    // mixed case, then a decoded zero byte
    add_item(PCT, 1'b0, 1'b1, 1'b0);
    add_item("f", 1'b0, 1'b1, 1'b0);
    add_item("F", 1'b0, 1'b1, 1'b0);
    add_item(PCT, 1'b0, 1'b1, 1'b0);
    add_item("0", 1'b0, 1'b1, 1'b0);
    add_item("0", 1'b0, 1'b1, 1'b0);
    // '%' broken by a non-digit
    add_item(PCT, 1'b0, 1'b0, 1'b0);
    add_item("G", 1'b0, 1'b0, 1'b0);
    // digit held, then a '%' restarts the escape
    add_item(PCT, 1'b0, 1'b0, 1'b0);
    add_item("9", 1'b0, 1'b0, 1'b0);
    add_item(PCT, 1'b0, 1'b0, 1'b0);
    add_item("a", 1'b0, 1'b0, 1'b0);
    add_item("B", 1'b1, 1'b0, 1'b0);
    // string ends with one digit held
    add_item(PCT, 1'b0, 1'b0, 1'b0);
    add_item("A", 1'b1, 1'b0, 1'b0);
    // string ends with '%' and a digit held plus a non-digit
    add_item(PCT, 1'b0, 1'b0, 1'b0);
    add_item("6", 1'b0, 1'b0, 1'b0);
    add_item(":", 1'b1, 1'b0, 1'b0);
    // '%' then '%' at the end, then a lone final '%'
    add_item(PCT, 1'b0, 1'b0, 1'b0);
    add_item(PCT, 1'b1, 1'b0, 1'b0);
    add_item(PCT, 1'b1, 1'b0, 1'b0);
    n_dir = n_queued;

    // random strings built from well-formed escapes, plain bytes and broken or partial escapes
    while (n_queued < n_dir + N_RANDOM) begin
      n_tok = $urandom_range(1, 8);
      calm  = ($urandom_range(0, 3) == 0);
      drain = (n_queued == n_dir) || ($urandom_range(0, 9) == 0);
      sbuf.delete();
      for (int t = 0; t < n_tok; t++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0, 1, 2, 3: begin
            sbuf.push_back(PCT);
            sbuf.push_back(rand_hex_char());
            sbuf.push_back(rand_hex_char());
          end
          4, 5: begin
            tok_b = 8'($urandom_range(0, 255));
            sbuf.push_back(tok_b);
          end
          6: begin
            sbuf.push_back(PCT);
            sbuf.push_back($urandom_range(0, 3) == 0 ? PCT : rand_nonhex());
          end
          7: begin
            sbuf.push_back(PCT);
            sbuf.push_back(rand_hex_char());
            sbuf.push_back($urandom_range(0, 3) == 0 ? PCT : rand_nonhex());
          end
          8: begin
            sbuf.push_back(PCT);
            sbuf.push_back(rand_hex_char());
          end
          default: begin
            sbuf.push_back(PCT);
          end
        endcase
      end
      foreach (sbuf[i]) begin
        add_item(sbuf[i], i == sbuf.size() - 1, calm, drain && i == 0);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // wait for all items to be taken and all decoded bytes to arrive
    while (n_accepted != n_queued || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d encoded bytes in %0d strings; checked %0d decoded bytes",
             n_accepted, n_strings, n_checked);
    $display("escapes decoded: %0d, broken or partial escapes: %0d", n_escapes, n_broken);
    if (n_fail == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
